@@ rtl/tcl_pkg.sv @@
// ----------------------------------------------------------------------------
// tcl_pkg
// Shared widths, status codes, register indexes and the request/response
// types between the tracker control and its load arithmetic unit.
// ----------------------------------------------------------------------------
package tcl_pkg;

  // field widths
  localparam int TickW    = 48;
  localparam int LoadW    = 16;
  localparam int StatW    = 3;
  localparam int ErrW     = 8;
  localparam int TpsW     = 14;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 14;

  // status codes reported on the result word
  localparam logic [StatW-1:0] STAT_INVALID  = 3'd0;
  localparam logic [StatW-1:0] STAT_NOT_INIT = 3'd1;
  localparam logic [StatW-1:0] STAT_INIT     = 3'd2;
  localparam logic [StatW-1:0] STAT_FINE     = 3'd3;
  localparam logic [StatW-1:0] STAT_ILL      = 3'd4;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_ENABLE  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_ERR = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_TPS     = 2'd2;

  // load constants
  localparam logic [LoadW-1:0] LOAD_RESET = 16'd100;
  localparam logic [LoadW-1:0] LOAD_ILL   = 16'd10000;
  localparam logic [LoadW-1:0] LOAD_MAX   = 16'hFFFF;

  // 10^10 = 9765625 * 2^10: odd part is multiplied, the power of two is a shift
  localparam logic [23:0] SCALE_ODD = 24'd9765625;

  // request to the load unit
  typedef struct packed {
    logic             start;
    logic [TickW-1:0] dt;
    logic [TickW-1:0] dus;
    logic [TpsW-1:0]  tps;
  } load_req_t;

  // response from the load unit
  typedef struct packed {
    logic             done;
    logic [LoadW-1:0] load;
  } load_rsp_t;

endpackage

@@ rtl/tcl_load_unit.sv @@
// ----------------------------------------------------------------------------
// tcl_load_unit
// Computes min(floor(dt * 10^10 / (dus * tps)), 65535) with one shared
// 83-bit adder: shift-add multiply of dt by the odd scale part, shift-add
// multiply of dus by tps, one saturation compare, then 16 restoring
// division steps.
// ----------------------------------------------------------------------------
module tcl_load_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  tcl_pkg::load_req_t  req,
  output tcl_pkg::load_rsp_t  rsp
);

  typedef enum logic [4:0] {
    U_IDLE = 5'b00001,
    U_MULN = 5'b00010,
    U_MULD = 5'b00100,
    U_CHK  = 5'b01000,
    U_DIV  = 5'b10000
  } ust_t;

  ust_t        st_r, st_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [71:0] acc_r, acc_nxt;
  logic [61:0] den_r, den_nxt;
  logic [71:0] mcand_r, mcand_nxt;
  logic [23:0] mplr_r, mplr_nxt;
  logic [47:0] dus_r, dus_nxt;
  logic [13:0] tps_r, tps_nxt;
  logic [61:0] rem_r, rem_nxt;
  logic [15:0] low_r, low_nxt;
  logic [15:0] q_r, q_nxt;

  logic [82:0] op_a, op_b, sum;
  logic        sub;
  logic        neg;

  // shared adder / subtractor
  assign sum = op_a + (sub ? ~op_b : op_b) + {82'd0, sub};
  assign neg = sum[82];

  // operand selection per step
  always_comb begin
    op_a = {11'd0, acc_r};
    op_b = {11'd0, mcand_r};
    sub  = 1'b0;
    case (st_r)
      U_MULN: begin
        op_a = {11'd0, acc_r};
        op_b = {11'd0, mcand_r};
      end
      U_MULD: begin
        op_a = {21'd0, den_r};
        op_b = {11'd0, mcand_r};
      end
      U_CHK: begin
        op_a = {1'b0, acc_r, 10'd0};
        op_b = {5'd0, den_r, 16'd0};
        sub  = 1'b1;
      end
      U_DIV: begin
        op_a = {20'd0, rem_r, low_r[15]};
        op_b = {21'd0, den_r};
        sub  = 1'b1;
      end
      default: begin
        sub = 1'b0;
      end
    endcase
  end

  // sequencer
  always_comb begin
    st_nxt    = st_r;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    den_nxt   = den_r;
    mcand_nxt = mcand_r;
    mplr_nxt  = mplr_r;
    dus_nxt   = dus_r;
    tps_nxt   = tps_r;
    rem_nxt   = rem_r;
    low_nxt   = low_r;
    q_nxt     = q_r;
    rsp.done  = 1'b0;
    rsp.load  = {q_r[14:0], ~neg};
    case (st_r)
      U_IDLE: begin
        if (req.start) begin
          acc_nxt   = '0;
          den_nxt   = '0;
          mcand_nxt = {24'd0, req.dt};
          mplr_nxt  = tcl_pkg::SCALE_ODD;
          dus_nxt   = req.dus;
          tps_nxt   = req.tps;
          cnt_nxt   = 5'd23;
          st_nxt    = U_MULN;
        end
      end
      U_MULN: begin
        if (mplr_r[0]) begin
          acc_nxt = sum[71:0];
        end
        mcand_nxt = {mcand_r[70:0], 1'b0};
        mplr_nxt  = {1'b0, mplr_r[23:1]};
        cnt_nxt   = cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          mcand_nxt = {24'd0, dus_r};
          mplr_nxt  = {10'd0, tps_r};
          cnt_nxt   = 5'd13;
          st_nxt    = U_MULD;
        end
      end
      U_MULD: begin
        if (mplr_r[0]) begin
          den_nxt = sum[61:0];
        end
        mcand_nxt = {mcand_r[70:0], 1'b0};
        mplr_nxt  = {1'b0, mplr_r[23:1]};
        cnt_nxt   = cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          st_nxt = U_CHK;
        end
      end
      U_CHK: begin
        // quotient of 2^16 or more saturates
        if (!neg) begin
          rsp.done = 1'b1;
          rsp.load = tcl_pkg::LOAD_MAX;
          st_nxt   = U_IDLE;
        end else begin
          rem_nxt = acc_r[67:6];
          low_nxt = {acc_r[5:0], 10'd0};
          q_nxt   = '0;
          cnt_nxt = 5'd15;
          st_nxt  = U_DIV;
        end
      end
      U_DIV: begin
        rem_nxt = neg ? {rem_r[60:0], low_r[15]} : sum[61:0];
        low_nxt = {low_r[14:0], 1'b0};
        q_nxt   = {q_r[14:0], ~neg};
        cnt_nxt = cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          rsp.done = 1'b1;
          st_nxt   = U_IDLE;
        end
      end
      default: begin
        st_nxt = U_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= U_IDLE;
      cnt_r <= '0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    acc_r   <= acc_nxt;
    den_r   <= den_nxt;
    mcand_r <= mcand_nxt;
    mplr_r  <= mplr_nxt;
    dus_r   <= dus_nxt;
    tps_r   <= tps_nxt;
    rem_r   <= rem_nxt;
    low_r   <= low_nxt;
    q_r     <= q_nxt;
  end

endmodule

@@ rtl/thread_cpu_load_tracker.sv @@
// A sample that needs a new load value gets its result word once the load unit
// is done; its shared adder does 24 + 14 multiply steps, one compare, then 16
// divide steps (the divide steps are skipped when the load saturates).
// Any other sample gives its result word in the cycle after acceptance.
// No new sample is taken while a load is being computed.
// Synchronous active-low reset: enabled, not initialised, load 100.
// ----------------------------------------------------------------------------
// thread_cpu_load_tracker
// Per-thread load tracker: five-state status machine, baseline latch, failure
// counting and load computation in hundredths of a percent.
// ----------------------------------------------------------------------------
module thread_cpu_load_tracker (
  input  logic                          clk,
  input  logic                          rst_n,
  // sample input
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_read_ok,
  input  logic [tcl_pkg::TickW-1:0]     in_cpu_ticks,
  input  logic [tcl_pkg::TickW-1:0]     in_time_us,
  // result output
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [tcl_pkg::LoadW-1:0]     out_load,
  output logic [tcl_pkg::StatW-1:0]     out_status,
  output logic [tcl_pkg::ErrW-1:0]      out_error_count,
  // configuration writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tcl_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [tcl_pkg::CfgDataW-1:0]  cfg_data
);

  typedef enum logic [1:0] {
    T_IDLE = 2'b01,
    T_CALC = 2'b10
  } tst_t;

  tst_t                          tst_r, tst_nxt;
  logic                          enable_r, enable_nxt;
  logic [7:0]                    max_err_r, max_err_nxt;
  logic [tcl_pkg::TpsW-1:0]      tps_r, tps_nxt;
  logic [tcl_pkg::StatW-1:0]     mode_r, mode_nxt;
  logic [tcl_pkg::ErrW-1:0]      fail_r, fail_nxt;
  logic [tcl_pkg::LoadW-1:0]     load_r, load_nxt;
  logic [tcl_pkg::TickW-1:0]     prev_ticks_r, prev_ticks_nxt;
  logic [tcl_pkg::TickW-1:0]     prev_time_r, prev_time_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [tcl_pkg::LoadW-1:0]     out_load_r, out_load_nxt;
  logic [tcl_pkg::StatW-1:0]     out_status_r, out_status_nxt;
  logic [tcl_pkg::ErrW-1:0]      out_err_r, out_err_nxt;

  logic                          in_acc;
  logic                          cfg_acc;
  logic [tcl_pkg::StatW-1:0]     mode_eff;
  logic [tcl_pkg::ErrW-1:0]      fail_inc;
  logic                          calc;
  tcl_pkg::load_req_t            req;
  tcl_pkg::load_rsp_t            rsp;

  // handshakes
  assign in_stall  = (tst_r != T_IDLE) | (out_valid_r & out_stall);
  assign in_acc    = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid & cfg_ready;

  // load arithmetic request
  assign mode_eff = enable_r ? mode_r : tcl_pkg::STAT_INVALID;
  assign fail_inc = (fail_r != 8'hFF) ? fail_r + 8'd1 : fail_r;
  assign req.dt   = in_cpu_ticks - prev_ticks_r;
  assign req.dus  = in_time_us - prev_time_r;
  assign req.tps  = tps_r;
  assign req.start = calc;

  tcl_load_unit u_load (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  // tracker state machine
  always_comb begin
    tst_nxt        = tst_r;
    enable_nxt     = enable_r;
    max_err_nxt    = max_err_r;
    tps_nxt        = tps_r;
    mode_nxt       = mode_r;
    fail_nxt       = fail_r;
    load_nxt       = load_r;
    prev_ticks_nxt = prev_ticks_r;
    prev_time_nxt  = prev_time_r;
    calc           = 1'b0;

    // configuration writes
    if (cfg_acc) begin
      case (cfg_index)
        tcl_pkg::CFG_ENABLE: begin
          enable_nxt = cfg_data[0];
          if (!cfg_data[0]) begin
            mode_nxt = tcl_pkg::STAT_INVALID;
          end else if (mode_r == tcl_pkg::STAT_INVALID) begin
            mode_nxt = tcl_pkg::STAT_NOT_INIT;
            fail_nxt = '0;
          end
        end
        tcl_pkg::CFG_MAX_ERR: max_err_nxt = cfg_data[7:0];
        tcl_pkg::CFG_TPS:     tps_nxt     = cfg_data;
        default:              max_err_nxt = max_err_r;
      endcase
    end

    // sample handling
    if (in_acc) begin
      mode_nxt = mode_eff;
      case (mode_eff)
        tcl_pkg::STAT_NOT_INIT: begin
          if (in_read_ok) begin
            prev_ticks_nxt = in_cpu_ticks;
            prev_time_nxt  = in_time_us;
            mode_nxt       = tcl_pkg::STAT_INIT;
          end
        end
        tcl_pkg::STAT_INIT, tcl_pkg::STAT_ILL, tcl_pkg::STAT_FINE: begin
          if (in_read_ok) begin
            calc           = (in_time_us > prev_time_r) && (tps_r != '0);
            prev_ticks_nxt = in_cpu_ticks;
            prev_time_nxt  = in_time_us;
            fail_nxt       = '0;
            mode_nxt       = tcl_pkg::STAT_FINE;
          end else if (mode_eff == tcl_pkg::STAT_FINE) begin
            fail_nxt = fail_inc;
            if (fail_inc >= max_err_r) begin
              load_nxt = tcl_pkg::LOAD_ILL;
              mode_nxt = tcl_pkg::STAT_ILL;
            end
          end
        end
        default: mode_nxt = mode_eff;
      endcase
      if (calc) begin
        tst_nxt = T_CALC;
      end
    end

    // load unit finished
    if (tst_r == T_CALC && rsp.done) begin
      load_nxt = rsp.load;
      tst_nxt  = T_IDLE;
    end
  end

  // result word register
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_load_nxt   = out_load_r;
    out_status_nxt = out_status_r;
    out_err_nxt    = out_err_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if ((in_acc && !calc) || (tst_r == T_CALC && rsp.done)) begin
      out_valid_nxt  = 1'b1;
      out_load_nxt   = load_nxt;
      out_status_nxt = mode_nxt;
      out_err_nxt    = fail_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_load        = out_load_r;
  assign out_status      = out_status_r;
  assign out_error_count = out_err_r;

  // control and tracker state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tst_r        <= T_IDLE;
      enable_r     <= 1'b1;
      max_err_r    <= 8'd3;
      tps_r        <= 14'd100;
      mode_r       <= tcl_pkg::STAT_NOT_INIT;
      fail_r       <= '0;
      load_r       <= tcl_pkg::LOAD_RESET;
      prev_ticks_r <= '0;
      prev_time_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      tst_r        <= tst_nxt;
      enable_r     <= enable_nxt;
      max_err_r    <= max_err_nxt;
      tps_r        <= tps_nxt;
      mode_r       <= mode_nxt;
      fail_r       <= fail_nxt;
      load_r       <= load_nxt;
      prev_ticks_r <= prev_ticks_nxt;
      prev_time_r  <= prev_time_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_load_r   <= out_load_nxt;
    out_status_r <= out_status_nxt;
    out_err_r    <= out_err_nxt;
  end

endmodule
